[rtl/cpu6502_alu_execute_top_macros.svh]
// Assertion macros used by the checker of the 6502 ALU execute block.
`ifndef CPU6502_ALU_EXECUTE_TOP_MACROS_SVH
`define CPU6502_ALU_EXECUTE_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define C6502_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define C6502_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define C6502_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/cpu6502alu_pkg.sv]
// Package with the operation codes and the register and flag types of the 6502 ALU.
package cpu6502alu_pkg;

   localparam int unsigned DataWidth = 8;

   // Operation codes; codes 24 to 31 mean nothing and change nothing.
   typedef enum logic [4:0] {
      OP_ADC = 5'd0,
      OP_AND = 5'd1,
      OP_ASL = 5'd2,
      OP_CMP = 5'd3,
      OP_CPX = 5'd4,
      OP_CPY = 5'd5,
      OP_DCP = 5'd6,
      OP_DEC = 5'd7,
      OP_EOR = 5'd8,
      OP_INC = 5'd9,
      OP_ISC = 5'd10,
      OP_LAX = 5'd11,
      OP_LDA = 5'd12,
      OP_LDX = 5'd13,
      OP_LDY = 5'd14,
      OP_LSR = 5'd15,
      OP_ORA = 5'd16,
      OP_ROL = 5'd17,
      OP_ROR = 5'd18,
      OP_RLA = 5'd19,
      OP_RRA = 5'd20,
      OP_SBC = 5'd21,
      OP_SLO = 5'd22,
      OP_SRE = 5'd23
   } op_type;

   // Programmer-visible registers and flags.
   typedef struct packed {
      logic [DataWidth-1:0] acc;
      logic [DataWidth-1:0] x;
      logic [DataWidth-1:0] y;
      logic                 carry;
      logic                 zero;
      logic                 overflow;
      logic                 negative;
   } state_type;

   localparam state_type StateReset = '0;

endpackage

[rtl/cpu6502alu_core.sv]
// Combinational 6502 data operation: one operand byte against the current registers.
module cpu6502alu_core (
   input  logic [4:0]                                op_code,
   input  logic [cpu6502alu_pkg::DataWidth-1:0]      operand,
   input  cpu6502alu_pkg::state_type                 state_cur,
   output logic [cpu6502alu_pkg::DataWidth-1:0]      mem_res,
   output cpu6502alu_pkg::state_type                 state_nxt
);
   import cpu6502alu_pkg::*;

   op_type               op;
   logic [DataWidth-1:0] inc_val;
   logic [DataWidth-1:0] dec_val;
   logic                 shl_cin;
   logic                 shr_cin;
   logic [DataWidth-1:0] shl_val;
   logic [DataWidth-1:0] shr_val;
   logic [DataWidth-1:0] add_b;
   logic                 add_cin;
   logic [DataWidth:0]   add_sum;
   logic                 add_ovf;
   logic [DataWidth-1:0] cmp_reg;
   logic [DataWidth-1:0] cmp_m;
   logic [DataWidth:0]   cmp_diff;

   assign op = op_type'(op_code);

   // Increment, decrement and the shift units for the read-modify-write forms.
   assign inc_val = operand + DataWidth'(1);
   assign dec_val = operand - DataWidth'(1);
   assign shl_cin = ((op == OP_ROL) || (op == OP_RLA)) ? state_cur.carry : 1'b0;
   assign shr_cin = ((op == OP_ROR) || (op == OP_RRA)) ? state_cur.carry : 1'b0;
   assign shl_val = {operand[DataWidth-2:0], shl_cin};
   assign shr_val = {shr_cin, operand[DataWidth-1:1]};

   // Adder operand: subtraction adds the complement; RRA takes the carry from its rotate.
   always_comb begin
      case (op)
         OP_SBC:  add_b = ~operand;
         OP_ISC:  add_b = ~inc_val;
         OP_RRA:  add_b = shr_val;
         default: add_b = operand;
      endcase
   end

   assign add_cin = (op == OP_RRA) ? operand[0] : state_cur.carry;
   assign add_sum = {1'b0, state_cur.acc} + {1'b0, add_b} + {{DataWidth{1'b0}}, add_cin};
   assign add_ovf = (~(state_cur.acc[DataWidth-1] ^ add_b[DataWidth-1]))
                    & (state_cur.acc[DataWidth-1] ^ add_sum[DataWidth-1]);

   // Compare: a borrow out of the 9-bit difference means the register is below M.
   always_comb begin
      case (op)
         OP_CPX:  cmp_reg = state_cur.x;
         OP_CPY:  cmp_reg = state_cur.y;
         default: cmp_reg = state_cur.acc;
      endcase
   end

   assign cmp_m    = (op == OP_DCP) ? dec_val : operand;
   assign cmp_diff = {1'b0, cmp_reg} - {1'b0, cmp_m};

   // Per-operation selection of the memory byte and the new registers and flags.
   always_comb begin
      mem_res   = operand;
      state_nxt = state_cur;
      case (op)
         OP_ADC, OP_SBC, OP_ISC, OP_RRA: begin
            if (op == OP_ISC) begin
               mem_res = inc_val;
            end else if (op == OP_RRA) begin
               mem_res = shr_val;
            end
            state_nxt.acc      = add_sum[DataWidth-1:0];
            state_nxt.carry    = add_sum[DataWidth];
            state_nxt.overflow = add_ovf;
            state_nxt.zero     = (add_sum[DataWidth-1:0] == '0);
            state_nxt.negative = add_sum[DataWidth-1];
         end
         OP_CMP, OP_CPX, OP_CPY, OP_DCP: begin
            if (op == OP_DCP) begin
               mem_res = dec_val;
            end
            state_nxt.carry    = ~cmp_diff[DataWidth];
            state_nxt.zero     = (cmp_diff[DataWidth-1:0] == '0);
            state_nxt.negative = cmp_diff[DataWidth-1];
         end
         OP_AND: begin
            state_nxt.acc      = state_cur.acc & operand;
            state_nxt.zero     = (state_nxt.acc == '0);
            state_nxt.negative = state_nxt.acc[DataWidth-1];
         end
         OP_EOR: begin
            state_nxt.acc      = state_cur.acc ^ operand;
            state_nxt.zero     = (state_nxt.acc == '0);
            state_nxt.negative = state_nxt.acc[DataWidth-1];
         end
         OP_ORA: begin
            state_nxt.acc      = state_cur.acc | operand;
            state_nxt.zero     = (state_nxt.acc == '0);
            state_nxt.negative = state_nxt.acc[DataWidth-1];
         end
         OP_ASL, OP_ROL: begin
            mem_res            = shl_val;
            state_nxt.carry    = operand[DataWidth-1];
            state_nxt.zero     = (shl_val == '0);
            state_nxt.negative = shl_val[DataWidth-1];
         end
         OP_LSR, OP_ROR: begin
            mem_res            = shr_val;
            state_nxt.carry    = operand[0];
            state_nxt.zero     = (shr_val == '0);
            state_nxt.negative = shr_val[DataWidth-1];
         end
         OP_RLA: begin
            mem_res            = shl_val;
            state_nxt.carry    = operand[DataWidth-1];
            state_nxt.acc      = state_cur.acc & shl_val;
            state_nxt.zero     = (state_nxt.acc == '0);
            state_nxt.negative = state_nxt.acc[DataWidth-1];
         end
         OP_SLO: begin
            mem_res            = shl_val;
            state_nxt.carry    = operand[DataWidth-1];
            state_nxt.acc      = state_cur.acc | shl_val;
            state_nxt.zero     = (state_nxt.acc == '0);
            state_nxt.negative = state_nxt.acc[DataWidth-1];
         end
         OP_SRE: begin
            mem_res            = shr_val;
            state_nxt.carry    = operand[0];
            state_nxt.acc      = state_cur.acc ^ shr_val;
            state_nxt.zero     = (state_nxt.acc == '0);
            state_nxt.negative = state_nxt.acc[DataWidth-1];
         end
         OP_DEC: begin
            mem_res            = dec_val;
            state_nxt.zero     = (dec_val == '0);
            state_nxt.negative = dec_val[DataWidth-1];
         end
         OP_INC: begin
            mem_res            = inc_val;
            state_nxt.zero     = (inc_val == '0);
            state_nxt.negative = inc_val[DataWidth-1];
         end
         OP_LAX: begin
            state_nxt.acc      = operand;
            state_nxt.x        = operand;
            state_nxt.zero     = (operand == '0);
            state_nxt.negative = operand[DataWidth-1];
         end
         OP_LDA: begin
            state_nxt.acc      = operand;
            state_nxt.zero     = (operand == '0);
            state_nxt.negative = operand[DataWidth-1];
         end
         OP_LDX: begin
            state_nxt.x        = operand;
            state_nxt.zero     = (operand == '0);
            state_nxt.negative = operand[DataWidth-1];
         end
         OP_LDY: begin
            state_nxt.y        = operand;
            state_nxt.zero     = (operand == '0);
            state_nxt.negative = operand[DataWidth-1];
         end
         default: begin
            mem_res   = operand;
            state_nxt = state_cur;
         end
      endcase
   end

endmodule

[rtl/cpu6502_alu_execute_top.sv]
// Top level of the 6502 binary-mode ALU execute unit.
//
// The req channel carries one beat per operation: a 5-bit operation code and
// an operand byte. The rsp channel returns one beat per request: the modified
// memory byte (or the operand unchanged), A, X, Y and the C, Z, V, N flags as
// they stand after the operation. Both channels use valid/ready.
//
// A request beat is captured in an input register; the ALU then works on it
// against the held registers and flags, and once the output register is free
// the result is written into it together with the new registers and flags.
// One beat per cycle is sustained while the receiver takes every response; the
// rate is set by the single ALU pass between the input and output registers.
//
// When the receiver stalls, the response holds and the input register keeps
// its beat; req_ready drops only while both registers are full. Reset clears
// A, X, Y and all flags to zero and empties both registers.
module cpu6502_alu_execute_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [4:0]                            req_operation,
   input  logic [cpu6502alu_pkg::DataWidth-1:0]  req_operand,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [cpu6502alu_pkg::DataWidth-1:0]  rsp_mem_out,
   output logic [cpu6502alu_pkg::DataWidth-1:0]  rsp_acc_out,
   output logic [cpu6502alu_pkg::DataWidth-1:0]  rsp_x_out,
   output logic [cpu6502alu_pkg::DataWidth-1:0]  rsp_y_out,
   output logic                                  rsp_carry_out,
   output logic                                  rsp_zero_out,
   output logic                                  rsp_overflow_out,
   output logic                                  rsp_negative_out
);
   import cpu6502alu_pkg::*;

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [4:0]           in_op_ff;
   logic [DataWidth-1:0] in_operand_ff;
   state_type            state_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [DataWidth-1:0] out_mem_ff;
   state_type            out_state_ff;
   logic [DataWidth-1:0] core_mem;
   state_type            core_state;
   logic                 advance;
   logic                 req_beat;

   // Output register frees up when it is empty or its beat is taken.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_beat  = req_valid && req_ready;

   assign in_valid_in  = req_beat || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_beat) begin
         in_op_ff      <= req_operation;
         in_operand_ff <= req_operand;
      end
   end

   cpu6502alu_core u_core (
      .op_code   (in_op_ff),
      .operand   (in_operand_ff),
      .state_cur (state_ff),
      .mem_res   (core_mem),
      .state_nxt (core_state)
   );

   // Architectural registers and flags, updated as each beat passes the ALU.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
      end else if (advance) begin
         state_ff <= core_state;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_mem_ff   <= core_mem;
         out_state_ff <= core_state;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mem_out      = out_mem_ff;
   assign rsp_acc_out      = out_state_ff.acc;
   assign rsp_x_out        = out_state_ff.x;
   assign rsp_y_out        = out_state_ff.y;
   assign rsp_carry_out    = out_state_ff.carry;
   assign rsp_zero_out     = out_state_ff.zero;
   assign rsp_overflow_out = out_state_ff.overflow;
   assign rsp_negative_out = out_state_ff.negative;

endmodule

[rtl/cpu6502alu_checker.sv]
// Port-level checker for the 6502 ALU execute unit, bound to the top level.
`include "cpu6502_alu_execute_top_macros.svh"

module cpu6502alu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_mem_out,
   input logic [7:0] rsp_acc_out,
   input logic [7:0] rsp_x_out,
   input logic [7:0] rsp_y_out,
   input logic       rsp_carry_out,
   input logic       rsp_zero_out,
   input logic       rsp_overflow_out,
   input logic       rsp_negative_out
);

   // The block comes out of reset with no response pending.
   `C6502_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid, "response valid right after reset")

   // Back-pressure reaches the request side only when the response side is stalled.
   `C6502_ASSERT_NOW(a_ready_only_stall, !req_ready,
      rsp_valid && !rsp_ready,
      "request stalled without a response stall")

   // An accepted request whose way to the output is free shows up as a response.
   `C6502_ASSERT_NEXT(a_beat_arrives,
      (req_valid && req_ready) ##1 (!rsp_valid || rsp_ready),
      rsp_valid,
      "accepted beat did not reach the response register")

   // A stalled response keeps its whole payload.
   `C6502_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_mem_out) && $stable(rsp_acc_out)
         && $stable(rsp_x_out) && $stable(rsp_y_out)
         && $stable({rsp_carry_out, rsp_zero_out, rsp_overflow_out, rsp_negative_out}),
      "stalled response changed")

endmodule

bind cpu6502_alu_execute_top cpu6502alu_checker u_cpu6502alu_checker (.*);
